### rtl/smd_pkg.sv
// Shared types and constants for the skeleton minutia detector.
// No dependencies; imported by smd_judge and skeleton_minutia_detector.
package smd_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 10;
    localparam int CNT_W     = 4;
    localparam int WIN_W     = 9;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic             is_minutia;
        logic             is_branch;
        logic [CNT_W-1:0] neighbor_count;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             judged_valid;
        logic             frame_end;
    } res_t;

endpackage

### rtl/smd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smd_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/smd_judge.sv
// Neighbor count and ending / branch decision for one 3x3 window.
// Depends on smd_pkg.
module smd_judge (
    input  logic [smd_pkg::WIN_W-1:0] window,
    input  logic                      judged_valid,
    input  logic [smd_pkg::POS_W-1:0] pos_x,
    input  logic [smd_pkg::POS_W-1:0] pos_y,
    input  logic                      frame_end,
    output smd_pkg::res_t             res
);
    import smd_pkg::*;

    logic [WIN_W-1:0] nb;
    logic [CNT_W-1:0] cnt;
    logic             center;
    logic             mark;

    always_comb
    begin
        nb     = window & ~(WIN_W'(1) << 4);
        center = window[4];
        cnt    = '0;
        for (int i = 0; i < WIN_W; i++)
        begin
            cnt = cnt + CNT_W'(nb[i]);
        end
        mark = judged_valid && center && (cnt == CNT_W'(1) || cnt > CNT_W'(2));

        res.is_minutia     = mark;
        res.is_branch      = mark && (cnt > CNT_W'(2));
        res.neighbor_count = judged_valid ? cnt : '0;
        res.pos_x          = judged_valid ? pos_x : '0;
        res.pos_y          = judged_valid ? pos_y : '0;
        res.judged_valid   = judged_valid;
        res.frame_end      = frame_end;
    end

endmodule

### rtl/skeleton_minutia_detector.sv
// Streaming ridge ending / branch point detector over a thinned skeleton.
// Depends on smd_pkg, smd_ram and smd_judge.
//
// The block takes one pixel per clock while in_ready is high and returns one
// result per pixel through an output register backed by a skid register, so
// one more pixel is taken while a result waits, then in_ready drops. The two
// line stores share one 2-bit RAM whose registered read is fetched one pixel
// ahead. After reset a clearing pass writes zeros to every address; in_ready
// stays low during that pass, configuration writes are taken at any time.
module skeleton_minutia_detector #(
    parameter int MAX_WIDTH  = smd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = smd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [smd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          pixel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          is_minutia,
    output logic                          is_branch,
    output logic [smd_pkg::CNT_W-1:0]     neighbor_count,
    output logic [smd_pkg::POS_W-1:0]     pos_x,
    output logic [smd_pkg::POS_W-1:0]     pos_y,
    output logic                          judged_valid,
    output logic                          frame_end
);
    import smd_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int DWC = (CW > CFG_W) ? CW : CFG_W;
    localparam int DWR = (RW > CFG_W) ? RW : CFG_W;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [WIN_W-1:0] win_reg, win_next;
    logic             clr_active_reg;
    logic [AW-1:0]    clr_addr_reg;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    res_t             out_res_reg, skid_res_reg, res_new;

    logic [DWC-1:0]   w_ext;
    logic [DWR-1:0]   h_ext;
    logic [CW-1:0]    w;
    logic [RW-1:0]    h;
    logic             accept;
    logic             in_img_col;
    logic             cur, prev, old, top, mid;
    logic [2:0]       col_bits;
    logic             jvalid, fend;
    logic [CW+9:0]    px_ext;
    logic [RW+9:0]    py_ext;
    logic             load_out;
    logic             out_load_skid, out_load_new, skid_load;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [1:0]       ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;
    assign in_ready  = !clr_active_reg && !skid_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        w_ext = DWC'(width_reg);
        if (w_ext == '0)
        begin
            w_ext = DWC'(1);
        end
        else if (w_ext > DWC'(MAX_WIDTH))
        begin
            w_ext = DWC'(MAX_WIDTH);
        end
        w = w_ext[CW-1:0];

        h_ext = DWR'(height_reg);
        if (h_ext == '0)
        begin
            h_ext = DWR'(1);
        end
        else if (h_ext > DWR'(MAX_HEIGHT))
        begin
            h_ext = DWR'(MAX_HEIGHT);
        end
        h = h_ext[RW-1:0];
    end

    always_comb
    begin
        in_img_col = col_reg < w;
        prev       = ram_rdata[0];
        old        = ram_rdata[1];
        cur        = in_img_col && (row_reg < h) && pixel;
        top        = in_img_col && (row_reg >= RW'(2)) && old;
        mid        = in_img_col && (row_reg >= RW'(1)) && prev;
        col_bits   = {cur, mid, top};
        win_next   = (col_reg == '0) ? WIN_W'(col_bits) : {win_reg[WIN_W-4:0], col_bits};

        jvalid = (col_reg >= CW'(1)) && (col_reg <= w) && (row_reg >= RW'(1)) && (row_reg <= h);
        fend   = (col_reg >= w) && (row_reg >= h);
        px_ext = {10'b0, col_reg} - (CW+10)'(1);
        py_ext = {10'b0, row_reg} - (RW+10)'(1);

        if (col_reg >= w)
        begin
            col_next = '0;
            row_next = (row_reg >= h) ? '0 : row_reg + RW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    always_comb
    begin
        ram_we    = clr_active_reg || (accept && in_img_col);
        ram_waddr = clr_active_reg ? clr_addr_reg : col_reg[AW-1:0];
        ram_wdata = clr_active_reg ? 2'b00 : {prev, cur};
        if (accept)
        begin
            ram_raddr = (col_next < CW'(MAX_WIDTH)) ? col_next[AW-1:0] : '0;
        end
        else
        begin
            ram_raddr = (col_reg < CW'(MAX_WIDTH)) ? col_reg[AW-1:0] : '0;
        end
    end

    smd_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    smd_judge u_judge (
        .window       (win_next),
        .judged_valid (jvalid),
        .pos_x        (px_ext[POS_W-1:0]),
        .pos_y        (py_ext[POS_W-1:0]),
        .frame_end    (fend),
        .res          (res_new)
    );

    always_comb
    begin
        load_out        = !out_valid_reg || out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load_skid   = 1'b0;
        out_load_new    = 1'b0;
        skid_load       = 1'b0;
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_load_skid   = 1'b1;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_load_new   = accept;
                out_valid_next = accept;
            end
        end
        else if (accept)
        begin
            skid_load       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            win_reg        <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAX_WIDTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                win_reg <= win_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_skid)
        begin
            out_res_reg <= skid_res_reg;
        end
        else if (out_load_new)
        begin
            out_res_reg <= res_new;
        end
        if (skid_load)
        begin
            skid_res_reg <= res_new;
        end
    end

    assign out_valid      = out_valid_reg;
    assign is_minutia     = out_res_reg.is_minutia;
    assign is_branch      = out_res_reg.is_branch;
    assign neighbor_count = out_res_reg.neighbor_count;
    assign pos_x          = out_res_reg.pos_x;
    assign pos_y          = out_res_reg.pos_y;
    assign judged_valid   = out_res_reg.judged_valid;
    assign frame_end      = out_res_reg.frame_end;

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !in_ready)
        else $error("transaction accepted during clearing pass");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result ahead of the output register");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fend) |=> (col_reg == '0 && row_reg == '0))
        else $error("scan counters did not wrap at frame end");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= CW'(MAX_WIDTH))
        else $error("column counter past maximum width");
`endif

endmodule
